// ----- sv/xlt_pkg.sv -----
// ============================================================================
// xlt_pkg
// Shared types for the table message deframer: event codes, the action codes
// passed from the parser front to the position back, and the queue entry.
// ============================================================================
package xlt_pkg;

    // Event codes on the result channel
    typedef enum logic [2:0] {
        EV_HEADER   = 3'd0,
        EV_STRING   = 3'd1,
        EV_FLOAT    = 3'd2,
        EV_BAD_TYPE = 3'd3,
        EV_BAD_SIZE = 3'd4,
        EV_OUTSIDE  = 3'd5,
        EV_TRUNC    = 3'd6
    } t_event;

    // Work handed from the front to the back
    typedef enum logic [2:0] {
        ACT_HEADER = 3'd0,  // latch dimensions, home the position, report them
        ACT_ERROR  = 3'd1,  // report a header error
        ACT_DATA   = 3'd2,  // report a value byte, step the cell on its last byte
        ACT_TRUNC  = 3'd3,  // optional single step, then report truncation
        ACT_MOVE   = 3'd4   // step the cell by a count, no report
    } t_act;

    typedef struct packed {
        t_act        act;
        t_event      kind;
        logic [15:0] word_a;   // height for header, cell count for move
        logic [15:0] word_b;   // width for header
        logic [7:0]  data;
        logic [7:0]  idx;
        logic        last;
        logic        pre_adv;  // truncation: step the cell before reporting
    } t_entry;

endpackage

// ----- sv/xlt_front.sv -----
// ============================================================================
// xlt_front
// Byte parser: assembles header and block words, tracks block and string
// lengths, and turns each byte into at most one queue entry.
// ============================================================================
module xlt_front
    import xlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_message,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam logic [15:0] TYPE_TABLE  = 16'd16;
    localparam logic [15:0] TYPE_FLOAT  = 16'd1;
    localparam logic [15:0] TYPE_STRING = 16'd2;
    localparam logic [15:0] TYPE_BLANK  = 16'd5;
    localparam logic [15:0] HEADER_SIZE = 16'd4;
    localparam logic [7:0]  FLOAT_LAST  = 8'd7;

    typedef enum logic [11:0] {
        PH_HTYPE  = 12'h001,
        PH_HSIZE  = 12'h002,
        PH_HEIGHT = 12'h004,
        PH_WIDTH  = 12'h008,
        PH_BTYPE  = 12'h010,
        PH_BSIZE  = 12'h020,
        PH_SLEN   = 12'h040,
        PH_SBYTE  = 12'h080,
        PH_FBYTE  = 12'h100,
        PH_BLANK  = 12'h200,
        PH_SKIP   = 12'h400,
        PH_HALT   = 12'h800
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_word_low,   n_word_low;
    logic [15:0] r_block_kind, n_block_kind;
    logic [15:0] r_block_left, n_block_left;
    logic [7:0]  r_str_left,   n_str_left;
    logic [7:0]  r_count,      n_count;
    logic [15:0] r_height,     n_height;

    logic        word_ph;
    logic        done;
    logic        err;
    logic        adv;
    logic        trunc;
    logic        push;
    logic        last;
    logic [15:0] w;
    logic [15:0] block_dec;
    logic [7:0]  str_dec;
    t_entry      e;

    always_comb begin
        n_phase      = r_phase;
        n_word_low   = r_word_low;
        n_block_kind = r_block_kind;
        n_block_left = r_block_left;
        n_str_left   = r_str_left;
        n_count      = r_count;
        n_height     = r_height;
        e            = '0;
        push         = 1'b0;
        err          = 1'b0;
        adv          = 1'b0;
        trunc        = 1'b0;
        last         = 1'b0;
        w            = {i_in_byte, r_word_low};
        block_dec    = (r_block_left != 16'd0) ? r_block_left - 16'd1 : r_block_left;
        str_dec      = r_str_left - 8'd1;
        word_ph      = (r_phase == PH_HTYPE) || (r_phase == PH_HSIZE) ||
                       (r_phase == PH_HEIGHT) || (r_phase == PH_WIDTH) ||
                       (r_phase == PH_BTYPE) || (r_phase == PH_BSIZE) ||
                       (r_phase == PH_BLANK);
        done         = word_ph && (r_count != 8'd0);

        // low byte first; r_count flags the pending high byte
        if (word_ph) begin
            if (r_count == 8'd0) begin
                n_word_low = i_in_byte;
                n_count    = 8'd1;
            end else begin
                n_count    = 8'd0;
            end
        end

        case (r_phase)
            PH_HTYPE: begin
                if (done) begin
                    if (w != TYPE_TABLE) begin
                        push    = 1'b1;
                        e.act   = ACT_ERROR;
                        e.kind  = EV_BAD_TYPE;
                        n_phase = PH_HALT;
                        err     = 1'b1;
                    end else begin
                        n_phase = PH_HSIZE;
                    end
                end
            end
            PH_HSIZE: begin
                if (done) begin
                    if (w != HEADER_SIZE) begin
                        push    = 1'b1;
                        e.act   = ACT_ERROR;
                        e.kind  = EV_BAD_SIZE;
                        n_phase = PH_HALT;
                        err     = 1'b1;
                    end else begin
                        n_phase = PH_HEIGHT;
                    end
                end
            end
            PH_HEIGHT: begin
                if (done) begin
                    n_height = w;
                    n_phase  = PH_WIDTH;
                end
            end
            PH_WIDTH: begin
                if (done) begin
                    push     = 1'b1;
                    e.act    = ACT_HEADER;
                    e.kind   = EV_HEADER;
                    e.word_a = r_height;
                    e.word_b = w;
                    n_phase  = PH_BTYPE;
                end
            end
            PH_BTYPE: begin
                if (done) begin
                    n_block_kind = w;
                    n_phase      = PH_BSIZE;
                end
            end
            PH_BSIZE: begin
                if (done) begin
                    n_block_left = w;
                    if (r_block_kind == TYPE_STRING) begin
                        n_phase = (w != 16'd0) ? PH_SLEN : PH_BTYPE;
                    end else if (r_block_kind == TYPE_FLOAT) begin
                        n_phase = (w != 16'd0) ? PH_FBYTE : PH_BTYPE;
                    end else if (r_block_kind == TYPE_BLANK) begin
                        n_phase = PH_BLANK;
                    end else begin
                        n_phase = (w != 16'd0) ? PH_SKIP : PH_BTYPE;
                    end
                end
            end
            PH_SLEN: begin
                n_block_left = block_dec;
                if (i_in_byte == 8'd0) begin
                    // empty string: just move to the next cell
                    push     = 1'b1;
                    e.act    = ACT_MOVE;
                    e.word_a = 16'd1;
                    adv      = 1'b1;
                    n_phase  = (block_dec != 16'd0) ? PH_SLEN : PH_BTYPE;
                end else begin
                    n_str_left = i_in_byte;
                    n_count    = 8'd0;
                    n_phase    = PH_SBYTE;
                end
            end
            PH_SBYTE: begin
                n_block_left = block_dec;
                n_str_left   = str_dec;
                last         = (str_dec == 8'd0);
                push         = 1'b1;
                e.act        = ACT_DATA;
                e.kind       = EV_STRING;
                e.data       = i_in_byte;
                e.idx        = r_count;
                e.last       = last;
                n_count      = r_count + 8'd1;
                if (last) begin
                    n_count = 8'd0;
                    adv     = 1'b1;
                    n_phase = (block_dec != 16'd0) ? PH_SLEN : PH_BTYPE;
                end
            end
            PH_FBYTE: begin
                n_block_left = block_dec;
                last         = (r_count >= FLOAT_LAST);
                push         = 1'b1;
                e.act        = ACT_DATA;
                e.kind       = EV_FLOAT;
                e.data       = i_in_byte;
                e.idx        = r_count;
                e.last       = last;
                n_count      = r_count + 8'd1;
                if (last) begin
                    n_count = 8'd0;
                    adv     = 1'b1;
                    n_phase = (block_dec != 16'd0) ? PH_FBYTE : PH_BTYPE;
                end
            end
            PH_BLANK: begin
                if (done) begin
                    push     = 1'b1;
                    e.act    = ACT_MOVE;
                    e.word_a = w;
                    n_phase  = PH_BTYPE;
                end
            end
            PH_SKIP: begin
                n_block_left = block_dec;
                if (block_dec == 16'd0) begin
                    n_phase = PH_BTYPE;
                end
            end
            PH_HALT: begin
                err = 1'b1;
            end
            default: begin
                err = 1'b1;
            end
        endcase

        // end of message: report truncation unless errored or cleanly between blocks
        if (i_end_of_message) begin
            trunc = !err && !((n_phase == PH_BTYPE) && (n_count == 8'd0));
            if (trunc) begin
                e         = '0;
                push      = 1'b1;
                e.act     = ACT_TRUNC;
                e.kind    = EV_TRUNC;
                e.data    = i_in_byte;
                e.pre_adv = adv;
            end
            n_phase      = PH_HTYPE;
            n_count      = 8'd0;
            n_str_left   = 8'd0;
            n_block_left = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HTYPE;
            r_word_low   <= '0;
            r_block_kind <= '0;
            r_block_left <= '0;
            r_str_left   <= '0;
            r_count      <= '0;
            r_height     <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_word_low   <= n_word_low;
            r_block_kind <= n_block_kind;
            r_block_left <= n_block_left;
            r_str_left   <= n_str_left;
            r_count      <= n_count;
            r_height     <= n_height;
        end
    end

    assign o_push  = i_accept && push;
    assign o_entry = e;

endmodule

// ----- sv/xlt_queue.sv -----
// ============================================================================
// xlt_queue
// Short FIFO of parser entries between the front and the back.
// ============================================================================
module xlt_queue
    import xlt_pkg::*;
#(
    parameter int AW = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int DEPTH = 1 << AW;
    localparam int CW    = AW + 1;

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

// ----- sv/xlt_back.sv -----
// ============================================================================
// xlt_back
// Owns the table dimensions and the current cell; executes queue entries,
// classifies cells as inside or outside, and drives the result register.
// ============================================================================
module xlt_back
    import xlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_cell_row,
    output logic [15:0] o_cell_column,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index,
    output logic        o_last_in_cell
);

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] left;
    } t_step;

    // One cell-skip step: finish inside the current row, or jump to the next
    // row start keeping the remainder; at width 0 the row takes the whole count.
    function automatic t_step skip_step(input logic [15:0] row,
                                        input logic [15:0] col,
                                        input logic [15:0] cnt,
                                        input logic [15:0] width);
        logic [15:0] room;
        t_step       s;
        room   = width - col;
        s.row  = row;
        s.col  = col;
        s.left = '0;
        if (width == 16'd0) begin
            s.row = row + cnt;
            s.col = '0;
        end else if (cnt >= room) begin
            s.row  = row + 16'd1;
            s.col  = '0;
            s.left = cnt - room;
        end else begin
            s.col = col + cnt;
        end
        return s;
    endfunction

    logic [15:0] r_row,       n_row;
    logic [15:0] r_col,       n_col;
    logic [15:0] r_height,    n_height;
    logic [15:0] r_width,     n_width;
    logic [15:0] r_move_left, n_move_left;
    logic        r_moving,    n_moving;
    logic        r_out_valid;

    t_event      r_out_kind;
    logic [15:0] r_out_row;
    logic [15:0] r_out_col;
    logic [7:0]  r_out_data;
    logic [7:0]  r_out_idx;
    logic        r_out_last;

    logic        out_free;
    logic        cell_in;
    logic        pop;
    logic        load;
    logic [15:0] step_cnt;
    t_step       st;
    t_event      ld_kind;
    logic [15:0] ld_row;
    logic [15:0] ld_col;
    logic [7:0]  ld_data;
    logic [7:0]  ld_idx;
    logic        ld_last;

    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        cell_in     = (r_row < r_height) && (r_col < r_width);
        step_cnt    = r_moving ? r_move_left :
                      ((i_head.act == ACT_MOVE) ? i_head.word_a : 16'd1);
        st          = skip_step(r_row, r_col, step_cnt, r_width);
        n_row       = r_row;
        n_col       = r_col;
        n_height    = r_height;
        n_width     = r_width;
        n_move_left = r_move_left;
        n_moving    = r_moving;
        pop         = 1'b0;
        load        = 1'b0;
        ld_kind     = EV_HEADER;
        ld_row      = '0;
        ld_col      = '0;
        ld_data     = '0;
        ld_idx      = '0;
        ld_last     = 1'b0;

        if (r_moving) begin
            n_row       = st.row;
            n_col       = st.col;
            n_move_left = st.left;
            n_moving    = (st.left != 16'd0);
        end else if (i_head_valid) begin
            case (i_head.act)
                ACT_MOVE: begin
                    pop         = 1'b1;
                    n_row       = st.row;
                    n_col       = st.col;
                    n_move_left = st.left;
                    n_moving    = (st.left != 16'd0);
                end
                ACT_HEADER: begin
                    if (out_free) begin
                        pop      = 1'b1;
                        load     = 1'b1;
                        n_height = i_head.word_a;
                        n_width  = i_head.word_b;
                        n_row    = '0;
                        n_col    = '0;
                        ld_kind  = EV_HEADER;
                        ld_row   = i_head.word_a;
                        ld_col   = i_head.word_b;
                    end
                end
                ACT_ERROR: begin
                    if (out_free) begin
                        pop     = 1'b1;
                        load    = 1'b1;
                        ld_kind = i_head.kind;
                    end
                end
                ACT_DATA: begin
                    if (out_free) begin
                        pop     = 1'b1;
                        load    = 1'b1;
                        ld_kind = cell_in ? i_head.kind : EV_OUTSIDE;
                        ld_row  = r_row;
                        ld_col  = r_col;
                        ld_data = i_head.data;
                        ld_idx  = i_head.idx;
                        ld_last = i_head.last;
                        if (i_head.last) begin
                            n_row = st.row;
                            n_col = st.col;
                        end
                    end
                end
                ACT_TRUNC: begin
                    if (out_free) begin
                        pop     = 1'b1;
                        load    = 1'b1;
                        ld_kind = EV_TRUNC;
                        ld_data = i_head.data;
                        if (i_head.pre_adv) begin
                            n_row = st.row;
                            n_col = st.col;
                        end
                        ld_row  = n_row;
                        ld_col  = n_col;
                    end
                end
                default: begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_height    <= '0;
            r_width     <= '0;
            r_move_left <= '0;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_height    <= n_height;
            r_width     <= n_width;
            r_move_left <= n_move_left;
            r_moving    <= n_moving;
            if (out_free) begin
                r_out_valid <= load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind <= ld_kind;
            r_out_row  <= ld_row;
            r_out_col  <= ld_col;
            r_out_data <= ld_data;
            r_out_idx  <= ld_idx;
            r_out_last <= ld_last;
        end
    end

    assign o_pop          = pop;
    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_cell_row     = r_out_row;
    assign o_cell_column  = r_out_col;
    assign o_data_byte    = r_out_data;
    assign o_byte_index   = r_out_idx;
    assign o_last_in_cell = r_out_last;

`ifndef SYNTHESIS
    a_skip_blocks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> !o_pop)
        else $error("entry taken during a cell skip");

    a_skip_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_move_left != 16'd0))
        else $error("cell skip running with nothing left");

    a_data_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == EV_STRING || r_out_kind == EV_FLOAT))
            |-> ((r_out_row < r_height) && (r_out_col < r_width)))
        else $error("data event reported for a cell outside the table");
`endif

endmodule

// ----- sv/xltable_stream_deframer_core.sv -----
// ============================================================================
// xltable_stream_deframer_core
// Path: an accepted byte's entry is registered in the queue, then the back
//   end loads its result into the result register once that is free.
// Throughput: one byte per cycle while the queue is not full; a blank block's
//   count word makes the back end skip cells one row boundary at a time (all
//   at once at width 0), while the queue goes on taking bytes until it fills.
// Reset: synchronous, active low; clears parser phase, counters, position,
//   dimensions and the queue. No clearing pass.
// ============================================================================
module xltable_stream_deframer_core
    import xlt_pkg::*;
#(
    parameter int QUEUE_AW = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_message,
    // event channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_cell_row,
    output logic [15:0] o_cell_column,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index,
    output logic        o_last_in_cell
);

    // Front: one byte per transfer, parse state advances on every transfer.
    // It never looks at the cell position, so it runs ahead of the back end.
    // Back: owns row/column and the table size; blank-cell skips iterate here
    // while the queue absorbs further bytes.

    logic   accept;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    t_entry push_entry;
    t_entry head_entry;

    // Stall comes from a registered fill count only.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    xlt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    xlt_queue #(
        .AW (QUEUE_AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_entry)
    );

    // Back end: result register, loads whenever it is empty or being drained.
    xlt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (q_valid),
        .i_head         (head_entry),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_kind   (o_event_kind),
        .o_cell_row     (o_cell_row),
        .o_cell_column  (o_cell_column),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_last_in_cell (o_last_in_cell)
    );

endmodule

// ----- verif/xlt_tb_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// xlt_tb_pkg
// Verification types and the event scoreboard for the table message
// deframer. The scoreboard parses the byte stream in step with the block.
// It queues the event that each accepted byte should raise, and it checks
// each observed event against the oldest one in that queue.
// ============================================================================
package xlt_tb_pkg;
    import xlt_pkg::*;

    typedef enum bit [3:0] {
        PH_HTYPE,
        PH_HSIZE,
        PH_HEIGHT,
        PH_WIDTH,
        PH_BTYPE,
        PH_BSIZE,
        PH_SLEN,
        PH_SBYTE,
        PH_FBYTE,
        PH_BLANK,
        PH_SKIP,
        PH_HALT
    } t_parse_phase;

    localparam bit [15:0] BLK_TABLE  = 16'd16;
    localparam bit [15:0] BLK_FLOAT  = 16'd1;
    localparam bit [15:0] BLK_STRING = 16'd2;
    localparam bit [15:0] BLK_BLANK  = 16'd5;
    localparam bit [15:0] HDR_SIZE   = 16'd4;
    localparam bit [7:0]  FLOAT_LEN  = 8'd8;

    typedef struct packed {
        t_event      kind;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  data;
        logic [7:0]  idx;
        logic        last;
    } t_cell_event;

    class xlt_event_scoreboard;
        t_parse_phase phase;
        bit [7:0]     lo_byte;
        bit [7:0]     str_left;
        bit [7:0]     val_pos;      // byte within a word, or index within a value
        bit [15:0]    blk_type;
        bit [15:0]    blk_left;
        bit [15:0]    row;
        bit [15:0]    col;
        bit [15:0]    height;
        bit [15:0]    width;

        t_cell_event  expected_events[$];
        int unsigned  n_checked;
        int unsigned  n_fail;
        int unsigned  kind_seen[8];

        function new();
            phase     = PH_HTYPE;
            lo_byte   = '0;
            str_left  = '0;
            val_pos   = '0;
            blk_type  = '0;
            blk_left  = '0;
            row       = '0;
            col       = '0;
            height    = '0;
            width     = '0;
            n_checked = 0;
            n_fail    = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function t_cell_event make_event(t_event k, logic [15:0] r, logic [15:0] c,
                                         logic [7:0] d, logic [7:0] i, logic l);
            t_cell_event ev;
            ev.kind = k;
            ev.row  = r;
            ev.col  = c;
            ev.data = d;
            ev.idx  = i;
            ev.last = l;
            return ev;
        endfunction

        // Column runs along the row, wrapping into the next row.
        function void step_cell();
            col = col + 16'd1;
            if (col >= width) begin
                col = '0;
                row = row + 16'd1;
            end
        endfunction

        function bit in_table();
            return (row < height) && (col < width);
        endfunction

        function void burn_block();
            if (blk_left != 0) blk_left = blk_left - 16'd1;
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        // Accepted byte: advance the parse and queue the event it raises.
        function void note_byte(bit [7:0] b, bit eom);
            t_parse_phase ph;
            bit [15:0]    w;
            bit           done;
            bit           err;
            bit           fire;
            bit           last;
            t_cell_event  ev;

            ph   = phase;
            w    = '0;
            done = 1'b0;
            err  = 1'b0;
            fire = 1'b0;
            ev   = '0;

            if (ph <= PH_BSIZE || ph == PH_BLANK) begin
                if (val_pos == 0) begin
                    lo_byte = b;
                    val_pos = 8'd1;
                end else begin
                    val_pos = '0;
                    w       = {b, lo_byte};
                    done    = 1'b1;
                end
            end

            case (ph)
                PH_HTYPE: if (done) begin
                    if (w != BLK_TABLE) begin
                        ev    = make_event(EV_BAD_TYPE, 0, 0, 0, 0, 0);
                        fire  = 1'b1;
                        err   = 1'b1;
                        phase = PH_HALT;
                    end else begin
                        phase = PH_HSIZE;
                    end
                end
                PH_HSIZE: if (done) begin
                    if (w != HDR_SIZE) begin
                        ev    = make_event(EV_BAD_SIZE, 0, 0, 0, 0, 0);
                        fire  = 1'b1;
                        err   = 1'b1;
                        phase = PH_HALT;
                    end else begin
                        phase = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: if (done) begin
                    height = w;
                    phase  = PH_WIDTH;
                end
                PH_WIDTH: if (done) begin
                    width = w;
                    row   = '0;
                    col   = '0;
                    ev    = make_event(EV_HEADER, height, width, 0, 0, 0);
                    fire  = 1'b1;
                    phase = PH_BTYPE;
                end
                PH_BTYPE: if (done) begin
                    blk_type = w;
                    phase    = PH_BSIZE;
                end
                PH_BSIZE: if (done) begin
                    blk_left = w;
                    case (blk_type)
                        BLK_STRING: phase = (w != 0) ? PH_SLEN : PH_BTYPE;
                        BLK_FLOAT:  phase = (w != 0) ? PH_FBYTE : PH_BTYPE;
                        BLK_BLANK:  phase = PH_BLANK;
                        default:    phase = (w != 0) ? PH_SKIP : PH_BTYPE;
                    endcase
                end
                PH_SLEN: begin
                    burn_block();
                    if (b == 0) begin
                        step_cell();
                        phase = (blk_left != 0) ? PH_SLEN : PH_BTYPE;
                    end else begin
                        str_left = b;
                        val_pos  = '0;
                        phase    = PH_SBYTE;
                    end
                end
                PH_SBYTE: begin
                    burn_block();
                    str_left = str_left - 8'd1;
                    last     = (str_left == 0);
                    ev   = make_event(in_table() ? EV_STRING : EV_OUTSIDE, row, col,
                                      b, val_pos, last);
                    fire = 1'b1;
                    val_pos = val_pos + 8'd1;
                    if (last) begin
                        val_pos = '0;
                        step_cell();
                        phase = (blk_left != 0) ? PH_SLEN : PH_BTYPE;
                    end
                end
                PH_FBYTE: begin
                    burn_block();
                    last = (val_pos >= FLOAT_LEN - 8'd1);
                    ev   = make_event(in_table() ? EV_FLOAT : EV_OUTSIDE, row, col,
                                      b, val_pos, last);
                    fire = 1'b1;
                    val_pos = val_pos + 8'd1;
                    if (last) begin
                        val_pos = '0;
                        step_cell();
                        phase = (blk_left != 0) ? PH_FBYTE : PH_BTYPE;
                    end
                end
                PH_BLANK: if (done) begin
                    repeat (w) step_cell();
                    phase = PH_BTYPE;
                end
                PH_SKIP: begin
                    burn_block();
                    if (blk_left == 0) phase = PH_BTYPE;
                end
                default: err = 1'b1;
            endcase

            if (eom) begin
                // Cut short anywhere but a clean block boundary, unless errored.
                if (!err && !(phase == PH_BTYPE && val_pos == 0)) begin
                    ev   = make_event(EV_TRUNC, row, col, b, 0, 0);
                    fire = 1'b1;
                end
                phase    = PH_HTYPE;
                val_pos  = '0;
                str_left = '0;
                blk_left = '0;
            end

            if (fire) expected_events.push_back(ev);
        endfunction

        function void report(string what, t_cell_event want, t_cell_event got);
            n_fail++;
            if (n_fail <= 10)
                $display("[%0t] %s: exp kind=%0d row=%0d col=%0d data=%02h idx=%0d last=%0d | got kind=%0d row=%0d col=%0d data=%02h idx=%0d last=%0d",
                         $time, what,
                         want.kind, want.row, want.col, want.data, want.idx, want.last,
                         got.kind, got.row, got.col, got.data, got.idx, got.last);
        endfunction

        function void check_event(t_event k, logic [15:0] r, logic [15:0] c,
                                  logic [7:0] d, logic [7:0] i, logic l);
            t_cell_event got;
            t_cell_event want;
            got = make_event(k, r, c, d, i, l);
            if (expected_events.size() == 0) begin
                report("unexpected event", '0, got);
            end else begin
                want = expected_events.pop_front();
                n_checked++;
                if (got.kind !== want.kind || got.row !== want.row ||
                    got.col !== want.col || got.data !== want.data ||
                    got.idx !== want.idx || got.last !== want.last) begin
                    report("event mismatch", want, got);
                end else begin
                    kind_seen[want.kind]++;
                end
            end
        endfunction

        function void flush_leftover();
            t_cell_event want;
            while (expected_events.size() != 0) begin
                want = expected_events.pop_front();
                report("event never arrived", want, '0);
            end
        endfunction
    endclass

endpackage

// ----- verif/tb_xltable_stream_deframer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_xltable_stream_deframer_core
// Self-checking bench for the table message deframer. A short directed
// sequence covers the header extremes, row wrap, zero width, cells outside
// the table, header errors and truncation. Random table messages follow:
// well-formed, cut short, or broken, plus raw noise. Both channels see
// random idle and stall bursts. Each observed event is checked against the
// scoreboard's parse of the same bytes.
// ============================================================================
module tb_xltable_stream_deframer_core;
    import xlt_pkg::*;
    import xlt_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_BYTES = 1300;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte  = '0;
    logic        in_eom   = 1'b0;
    logic        out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_event_kind;
    logic [15:0] o_cell_row;
    logic [15:0] o_cell_column;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_byte_index;
    logic        o_last_in_cell;

    xlt_event_scoreboard sb;
    bit [7:0]    msg[$];          // message under construction
    int unsigned bytes_sent  = 0;
    int unsigned msgs_sent   = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    bit          send_idle   = 1'b0;
    bit          sink_idle   = 1'b0;
    bit          quiet       = 1'b0;  // no idling at all, used for the tail of the run

    always #2 i_clk = ~i_clk;

    xltable_stream_deframer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (in_byte),
        .i_end_of_message (in_eom),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_event_kind     (o_event_kind),
        .o_cell_row       (o_cell_row),
        .o_cell_column    (o_cell_column),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_last_in_cell   (o_last_in_cell)
    );

    // ------------------------------------------------------------------------
    // Watchdog: a hung handshake ends the run here.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_xltable_stream_deframer_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Event sink stall: random stall bursts, driven on the falling
    // edge so the block sees a settled value at the rising edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (quiet || !sink_idle) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the rising edge. A byte transfer
    // feeds the scoreboard's parse; an event transfer is checked against it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall)
                sb.note_byte(in_byte, in_eom);
            if (o_out_valid && !out_stall)
                sb.check_event(t_event'(o_event_kind), o_cell_row, o_cell_column,
                               o_data_byte, o_byte_index, o_last_in_cell);
        end
    end

    // One byte transfer; entered and left at a falling edge. Valid stays high
    // across back-to-back transfers and drops only for an idle burst.
    task automatic send_byte(input bit [7:0] b, input bit eom);
        int unsigned gap;
        if (send_idle && !quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eom   <= eom;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Send the first n bytes of the built message, end marker on the last.
    task automatic send_msg(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_byte(msg[k], k == n - 1);
        msgs_sent++;
    endtask

    // Hold the sender until every queued event has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic void push_word(bit [15:0] w);
        msg.push_back(w[7:0]);
        msg.push_back(w[15:8]);
    endfunction

    // One random block appended to msg.
    function automatic void add_block();
        int unsigned sel;
        int unsigned cnt;
        int unsigned len;
        int unsigned base;
        bit [15:0]   size;
        bit [15:0]   kind;
        sel = $urandom_range(0, 9);
        if (sel <= 2) begin
            // strings; size patched once the body is known
            push_word(BLK_STRING);
            base = msg.size();
            push_word(16'd0);
            cnt = $urandom_range(0, 4);
            repeat (cnt) begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 255)
                                                   : $urandom_range(0, 6);
                msg.push_back(len[7:0]);
                repeat (len) msg.push_back($urandom_range(0, 255));
            end
            size = msg.size() - base - 2;
            // short size word: the string in flight is still read in full
            if ($urandom_range(0, 5) == 0) size = $urandom_range(0, size);
            msg[base]     = size[7:0];
            msg[base + 1] = size[15:8];
        end else if (sel <= 4) begin
            push_word(BLK_FLOAT);
            cnt  = $urandom_range(0, 3);
            size = 8 * cnt;
            if (cnt != 0 && $urandom_range(0, 4) == 0) size = size - $urandom_range(1, 7);
            push_word(size);
            repeat (8 * cnt) msg.push_back($urandom_range(0, 255));
        end else if (sel <= 6) begin
            // size word is don't-care, one count word follows
            push_word(BLK_BLANK);
            push_word($urandom_range(0, 65535));
            push_word(($urandom_range(0, 9) == 0) ? $urandom_range(13, 300)
                                                  : $urandom_range(0, 12));
        end else begin
            kind = $urandom_range(0, 65535);
            if (kind == BLK_FLOAT || kind == BLK_STRING || kind == BLK_BLANK)
                kind = kind ^ 16'h8000;
            size = (sel == 9) ? 16'd0 : 16'($urandom_range(1, 6));
            push_word(kind);
            push_word(size);
            repeat (size) msg.push_back($urandom_range(0, 255));
        end
    endfunction

    function automatic void build_table(bit [15:0] h, bit [15:0] w, int unsigned n_blocks);
        msg.delete();
        push_word(BLK_TABLE);
        push_word(HDR_SIZE);
        push_word(h);
        push_word(w);
        repeat (n_blocks) add_block();
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned n;
        int unsigned stop_at;
        bit [15:0]   h;
        bit [15:0]   w;

        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extreme height with zero width; a full-range blank count (with an
        // all-ones size word that must be ignored) lands just past the last row; one
        // more wraps the row to 0. A float whose block size is short of the
        // value: all 8 bytes still pass, as outside events since width is 0.
        build_table(16'hFFFF, 16'h0000, 0);
        push_word(BLK_BLANK); push_word(16'hFFFF); push_word(16'hFFFF);
        push_word(BLK_BLANK); push_word(16'h0000); push_word(16'h0001);
        push_word(BLK_FLOAT); push_word(16'd3);
        repeat (4) begin msg.push_back(8'h00); msg.push_back(8'hFF); end
        send_msg(msg.size());

        // Bad type word, then the end marker lands while errored: silent.
        msg.delete();
        push_word(16'hFFFF);
        msg.push_back(8'h00);
        send_msg(msg.size());

        // Bad size word with the end marker on the same byte.
        msg.delete();
        push_word(BLK_TABLE);
        push_word(16'd5);
        send_msg(msg.size());

        // A string, an empty string, then a block type word cut in half.
        build_table(16'd1, 16'd2, 0);
        push_word(BLK_STRING); push_word(16'd5);
        msg.push_back(8'd3);
        msg.push_back("x"); msg.push_back("y"); msg.push_back("z");
        msg.push_back(8'd0);
        msg.push_back(8'h01);
        send_msg(msg.size());

        drain();

        // Random part.
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if (bytes_sent > stop_at - RANDOM_BYTES / 6) quiet = 1'b1;
            send_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            msg.delete();
            if (r < 85) begin
                case ($urandom_range(0, 9))
                    0: begin
                        h = $urandom_range(0, 4);
                        w = '0;
                    end
                    1: begin
                        h = $urandom_range(0, 65535);
                        w = $urandom_range(0, 65535);
                    end
                    2: begin
                        h = '0;
                        w = $urandom_range(1, 4);
                    end
                    default: begin
                        h = $urandom_range(1, 4);
                        w = $urandom_range(1, 4);
                    end
                endcase
                build_table(h, w, $urandom_range(1, 5));
                n = msg.size();
                if (r >= 70) n = $urandom_range(1, msg.size());  // cut short
                send_msg(n);
            end else if (r < 92) begin
                if ($urandom_range(0, 1) == 0) begin
                    push_word(BLK_TABLE ^ 16'($urandom_range(1, 65535)));
                end else begin
                    push_word(BLK_TABLE);
                    push_word(HDR_SIZE ^ 16'($urandom_range(1, 65535)));
                end
                repeat ($urandom_range(0, 6)) msg.push_back($urandom_range(0, 255));
                send_msg(msg.size());
            end else begin
                // raw noise with stray end markers
                n = $urandom_range(1, 10);
                for (int unsigned k = 0; k < n; k++)
                    send_byte($urandom_range(0, 255),
                              (k == n - 1) || ($urandom_range(0, 3) == 0));
                msgs_sent++;
            end
            if (!quiet && $urandom_range(0, 9) == 0) drain();
        end

        in_valid <= 1'b0;
        drain();
        repeat (8) @(negedge i_clk);
        sb.flush_leftover();

        $display("Run covered %0d bytes in %0d messages; %0d events checked, %0d failures.",
                 bytes_sent, msgs_sent, sb.n_checked, sb.n_fail);
        $display({"Events: header %0d, string %0d, float %0d, bad type %0d, ",
                  "bad size %0d, outside %0d, truncated %0d."},
                 sb.kind_seen[EV_HEADER], sb.kind_seen[EV_STRING], sb.kind_seen[EV_FLOAT],
                 sb.kind_seen[EV_BAD_TYPE], sb.kind_seen[EV_BAD_SIZE],
                 sb.kind_seen[EV_OUTSIDE], sb.kind_seen[EV_TRUNC]);
        if (sb.n_fail == 0) begin
            $display("tb_xltable_stream_deframer_core: PASS");
        end else begin
            $display("tb_xltable_stream_deframer_core: FAIL");
        end
        $finish;
    end

endmodule
